FILE: rtl/camera_point_projection_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the camera point projection core
// Concurrent checks on clk, disabled while rst_n is low; empty when
// NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef CAMERA_POINT_PROJECTION_CORE_MACROS_SVH
`define CAMERA_POINT_PROJECTION_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property holds at every edge outside reset
`define CPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition implies a consequence in the following cycle
`define CPP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define CPP_ASSERT(lbl, prop, msg)
`define CPP_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

FILE: rtl/cam_proj_pkg.sv
// ----------------------------------------------------------------------------
// cam_proj_pkg
// Shared constants, register codes and saturating helpers of the projection core.
// ----------------------------------------------------------------------------
`default_nettype none

package cam_proj_pkg;

  localparam int NORM_FRAC_BITS_DEF = 24;
  // quotient bits of the normalized ratio (magnitude limit 2^62-1)
  localparam int QUO_BITS = 62;
  // signed width of a camera frame coordinate, Q.22 mm
  localparam int CAM_W = 49;
  localparam int DIV_LAT = QUO_BITS + 2;
  localparam int MUL_LAT = 3;

  localparam logic [63:0] NORM_MAX  = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

  localparam logic [63:0] ROW_X_RST = 64'd16384;
  localparam logic [63:0] ROW_Y_RST = 64'd1 << 30;
  localparam logic [63:0] ROW_Z_RST = 64'd1 << 46;

  typedef enum logic [3:0] {
    CFG_ROW_X     = 4'd0,
    CFG_ROW_Y     = 4'd1,
    CFG_ROW_Z     = 4'd2,
    CFG_LENS      = 4'd3,
    CFG_RADIAL    = 4'd4,
    CFG_TANGENT   = 4'd5,
    CFG_DIST_EN   = 4'd6,
    CFG_CAL_VALID = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic               ovf;
    logic signed [63:0] val;
  } sat_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } pix_t;

  // 64-bit add, clamped to the signed range
  function automatic sat_t sat_add(input logic signed [63:0] a, input logic signed [63:0] b);
    logic [64:0] s;
    sat_t        r;
    s     = {a[63], a} + {b[63], b};
    r.ovf = s[64] ^ s[63];
    r.val = r.ovf ? (s[64] ? INT64_MIN : INT64_MAX) : s[63:0];
    return r;
  endfunction

  // clamp a 64-bit value to the signed 32-bit range
  function automatic pix_t clamp32(input logic signed [63:0] a);
    pix_t r;
    r.ovf = !((&a[63:31]) || !(|a[63:31]));
    r.val = r.ovf ? (a[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : a[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cam_proj_mul.sv
// ----------------------------------------------------------------------------
// cam_proj_mul
// Pipelined signed 64x64 multiply, floor shift right and 64-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module cam_proj_mul #(
  parameter int SHIFT = 12
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic signed [63:0]      y,
  output logic                    clamp
);
  import cam_proj_pkg::*;

  logic [63:0]  ua, ub;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic         neg1_r, neg2_r;
  logic [127:0] prod_r;
  logic [127:0] q, q1;
  logic         rem;
  logic         ovf_nxt;
  logic [63:0]  y_nxt;
  logic [63:0]  y_r;
  logic         clamp_r;

  assign ua = a[63] ? -a : a;
  assign ub = b[63] ? -b : b;

  // stage 1: four 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= a[63] ^ b[63];
      p00_r  <= ua[31:0]  * ub[31:0];
      p01_r  <= ua[31:0]  * ub[63:32];
      p10_r  <= ua[63:32] * ub[31:0];
      p11_r  <= ua[63:32] * ub[63:32];
    end
  end

  // stage 2: assemble the full product
  always_ff @(posedge clk) begin
    if (en) begin
      neg2_r <= neg1_r;
      prod_r <= {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
              + {p11_r, 64'd0};
    end
  end

  // stage 3: floor shift and saturate
  always_comb begin
    q   = prod_r >> SHIFT;
    rem = |prod_r[SHIFT-1:0];
    q1  = q + {127'd0, neg2_r & rem};
    if (!neg2_r) begin
      ovf_nxt = |q1[127:63];
      y_nxt   = ovf_nxt ? INT64_MAX : q1[63:0];
    end else begin
      ovf_nxt = (|q1[127:64]) || (q1[63] && (|q1[62:0]));
      y_nxt   = ovf_nxt ? INT64_MIN : -q1[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r     <= y_nxt;
      clamp_r <= ovf_nxt;
    end
  end

  assign y     = y_r;
  assign clamp = clamp_r;

endmodule

`default_nettype wire

FILE: rtl/cam_proj_div.sv
// ----------------------------------------------------------------------------
// cam_proj_div
// Pipelined restoring divider: |num| * 2^F / den, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cam_proj_div #(
  parameter int FRAC_BITS = cam_proj_pkg::NORM_FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic signed [cam_proj_pkg::CAM_W-1:0] num,
  input  wire logic signed [cam_proj_pkg::CAM_W-1:0] den,
  output logic signed [63:0]                         quo,
  output logic                                       ovf
);
  import cam_proj_pkg::*;

  localparam int MW = CAM_W - 1;
  localparam int QB = QUO_BITS;

  logic [CAM_W-1:0] num_neg;
  logic [MW-1:0]    un0, r0;
  logic [MW-1:0]    rem_r [QB+1];
  logic [QB-1:0]    q_r   [QB+1];
  logic             neg_r [QB+1];
  logic             ovf_r [QB+1];
  logic [MW-1:0]    un_r  [QB];
  logic [MW-1:0]    ud_r  [QB];
  logic [63:0]      res;
  logic [63:0]      quo_r;
  logic             ovf_out_r;

  assign num_neg = -num;
  assign un0     = num[MW] ? num_neg[MW-1:0] : num[MW-1:0];
  // bits of the scaled numerator above the quotient range
  assign r0      = un0 >> (QB - FRAC_BITS);

  // setup stage: magnitude, leading remainder, ratio overflow
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= r0;
      q_r[0]   <= '0;
      neg_r[0] <= num[MW];
      ovf_r[0] <= (r0 >= den[MW-1:0]);
      un_r[0]  <= un0;
      ud_r[0]  <= den[MW-1:0];
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int J = QB - 1 - k;
    logic        nb;
    logic [MW:0] trial, diff;
    logic        ge;

    if (J >= FRAC_BITS) begin : g_bit
      assign nb = un_r[k][J-FRAC_BITS];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign trial = {rem_r[k], nb};
    assign ge    = trial >= {1'b0, ud_r[k]};
    assign diff  = trial - {1'b0, ud_r[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[MW-1:0] : trial[MW-1:0];
        q_r[k+1]   <= {q_r[k][QB-2:0], ge};
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end

    if (k < QB - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          un_r[k+1] <= un_r[k];
          ud_r[k+1] <= ud_r[k];
        end
      end
    end
  end

  // apply saturation and sign
  assign res = ovf_r[QB] ? NORM_MAX : {{(64-QB){1'b0}}, q_r[QB]};

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r     <= neg_r[QB] ? -res : res;
      ovf_out_r <= ovf_r[QB];
    end
  end

  assign quo = quo_r;
  assign ovf = ovf_out_r;

endmodule

`default_nettype wire

FILE: rtl/camera_point_projection_core.sv
// The pipeline holds 88 stages plus the output register. Throughput: one item
// per cycle while the output is not stalled; the bit-per-stage divider with its
// 62 quotient-bit stages and the chain of multipliers set the depth.
// A stall only blocks input when the last stage holds an item that cannot move.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// calibration: identity rotation, zero translation, calibration not valid.
`default_nettype none
`include "camera_point_projection_core_macros.svh"

// ----------------------------------------------------------------------------
// camera_point_projection_core
// Rigid transform, perspective divide, lens distortion and pixel mapping.
// ----------------------------------------------------------------------------
module camera_point_projection_core #(
  parameter int NORMALIZED_FRACTION_BITS = cam_proj_pkg::NORM_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_pixel_u,
  output logic signed [31:0]      out_pixel_v,
  output logic                    out_projected,
  output logic                    out_saturated,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [63:0]        cfg_wdata
);
  import cam_proj_pkg::*;

  localparam int F          = NORMALIZED_FRACTION_BITS;
  localparam int DIST_LAT   = 22;
  localparam int PIPE_DEPTH = 2 + DIV_LAT + DIST_LAT;
  localparam int LAST       = PIPE_DEPTH - 1;
  localparam int REJ_LEN    = PIPE_DEPTH - 2;
  localparam logic [63:0] ONE_NORM = 64'd1 << F;

  // configuration registers
  logic [63:0] row_x_r, row_y_r, row_z_r, lens_r;
  logic [47:0] radial_r;
  logic [31:0] tang_r;
  logic        dist_en_r, cal_valid_r;

  logic                    en;
  logic [PIPE_DEPTH-1:0]   vld_r;
  logic [63:0]             rows [3];
  logic signed [31:0]      pts  [3];
  logic signed [47:0]      prd_r [3][3];
  logic signed [CAM_W-1:0] cam_r [3];
  logic                    rej_nxt;
  logic                    rej_d_r [REJ_LEN];

  // divider outputs (offset 0 of the distortion section)
  logic signed [63:0] xn, yn;
  logic               ovf_x, ovf_y;
  logic signed [63:0] xn_d_r [18];
  logic signed [63:0] yn_d_r [18];
  logic               dvf_d_r [18];
  logic               dnew [18];
  logic               dfl_r [18];

  logic signed [63:0] k1s, k2s, k3s, p1s, p2s;
  logic signed [63:0] xx, yy, xy, r4, k1r2, r6, k2r4, k3r6;
  logic               c_xx, c_yy, c_xy, c_r4, c_k1, c_r6, c_k2, c_k3;
  sat_t               s_r2, s_xx2, s_yy2, s_ax, s_ay, s_rad1, s_rad2, s_rad3;
  logic signed [63:0] r2_r, xx2_r, yy2_r, rad3_r;
  logic signed [63:0] xy_d_r   [11];
  logic signed [63:0] ax_d_r   [10];
  logic signed [63:0] ay_d_r   [10];
  logic signed [63:0] r2_d_r   [3];
  logic signed [63:0] rad1_d_r [3];
  logic signed [63:0] rad2_d_r [3];

  logic signed [63:0] xr, yr, xp1, xp2, yp1, yp2;
  logic               c_xr, c_yr, c_xp1, c_xp2, c_yp1, c_yp2;
  sat_t               s_xa, s_xd, s_ya, s_yd;
  logic signed [63:0] xd_r, yd_r;

  logic signed [63:0] xs, ys, fxs, fys, cxs, cys, mu, mv;
  logic               c_mu, c_mv;
  logic               fl18;
  logic               fl_d_r [3];
  sat_t               s_u, s_v;
  pix_t               pu, pv;
  logic signed [31:0] u_r, v_r;
  logic               sat_r;

  logic               ld;
  logic               out_valid_r, out_projected_r, out_saturated_r;
  logic signed [31:0] out_pixel_u_r, out_pixel_v_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r     <= ROW_X_RST;
      row_y_r     <= ROW_Y_RST;
      row_z_r     <= ROW_Z_RST;
      lens_r      <= '0;
      radial_r    <= '0;
      tang_r      <= '0;
      dist_en_r   <= 1'b0;
      cal_valid_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_X:     row_x_r     <= cfg_wdata;
        CFG_ROW_Y:     row_y_r     <= cfg_wdata;
        CFG_ROW_Z:     row_z_r     <= cfg_wdata;
        CFG_LENS:      lens_r      <= cfg_wdata;
        CFG_RADIAL:    radial_r    <= cfg_wdata[47:0];
        CFG_TANGENT:   tang_r      <= cfg_wdata[31:0];
        CFG_DIST_EN:   dist_en_r   <= cfg_wdata[0];
        CFG_CAL_VALID: cal_valid_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- handshake
  // stall only when the last stage holds an item the output cannot take
  assign en       = !vld_r[LAST] || !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], in_valid};
    end
  end

  // --------------------------------------------------- rigid transform
  assign rows[0] = row_x_r;
  assign rows[1] = row_y_r;
  assign rows[2] = row_z_r;
  assign pts[0]  = in_point_x;
  assign pts[1]  = in_point_y;
  assign pts[2]  = in_point_z;

  // stage 1: rotation products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prd_r[i][j] <= $signed(rows[i][16*j +: 16]) * pts[j];
        end
      end
    end
  end

  // stage 2: sum products and add translation
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cam_r[i] <= {{(CAM_W-48){prd_r[i][0][47]}}, prd_r[i][0]}
                  + {{(CAM_W-48){prd_r[i][1][47]}}, prd_r[i][1]}
                  + {{(CAM_W-48){prd_r[i][2][47]}}, prd_r[i][2]}
                  + {{(CAM_W-38){rows[i][63]}}, rows[i][63:48], 22'd0};
      end
    end
  end

  // reject on invalid calibration or depth not positive; carry to the end
  assign rej_nxt = !cal_valid_r || cam_r[2][CAM_W-1] || (cam_r[2] == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      rej_d_r[0] <= rej_nxt;
      for (int k = 1; k < REJ_LEN; k++) rej_d_r[k] <= rej_d_r[k-1];
    end
  end

  // --------------------------------------------------- perspective divide
  cam_proj_div #(.FRAC_BITS(F)) u_div_x (
    .clk(clk), .en(en), .num(cam_r[0]), .den(cam_r[2]), .quo(xn), .ovf(ovf_x)
  );

  cam_proj_div #(.FRAC_BITS(F)) u_div_y (
    .clk(clk), .en(en), .num(cam_r[1]), .den(cam_r[2]), .quo(yn), .ovf(ovf_y)
  );

  // delay normalized coords and divide flag to the distortion taps
  always_ff @(posedge clk) begin
    if (en) begin
      xn_d_r[0]  <= xn;
      yn_d_r[0]  <= yn;
      dvf_d_r[0] <= ovf_x | ovf_y;
      for (int k = 1; k < 18; k++) begin
        xn_d_r[k]  <= xn_d_r[k-1];
        yn_d_r[k]  <= yn_d_r[k-1];
        dvf_d_r[k] <= dvf_d_r[k-1];
      end
    end
  end

  // --------------------------------------------------- lens distortion
  assign k1s = {{48{radial_r[15]}}, radial_r[15:0]};
  assign k2s = {{48{radial_r[31]}}, radial_r[31:16]};
  assign k3s = {{48{radial_r[47]}}, radial_r[47:32]};
  assign p1s = {{48{tang_r[15]}}, tang_r[15:0]};
  assign p2s = {{48{tang_r[31]}}, tang_r[31:16]};

  // squares and cross term
  cam_proj_mul #(.SHIFT(F)) u_m_xx (.clk(clk), .en(en), .a(xn), .b(xn), .y(xx), .clamp(c_xx));
  cam_proj_mul #(.SHIFT(F)) u_m_yy (.clk(clk), .en(en), .a(yn), .b(yn), .y(yy), .clamp(c_yy));
  cam_proj_mul #(.SHIFT(F)) u_m_xy (.clk(clk), .en(en), .a(xn), .b(yn), .y(xy), .clamp(c_xy));

  assign s_r2  = sat_add(xx, yy);
  assign s_xx2 = sat_add(xx, xx);
  assign s_yy2 = sat_add(yy, yy);
  assign s_ax  = sat_add(r2_r, xx2_r);
  assign s_ay  = sat_add(r2_r, yy2_r);

  // radial powers and coefficient terms
  cam_proj_mul #(.SHIFT(F))  u_m_r4 (.clk(clk), .en(en), .a(r2_r), .b(r2_r), .y(r4),
                                     .clamp(c_r4));
  cam_proj_mul #(.SHIFT(12)) u_m_k1 (.clk(clk), .en(en), .a(k1s), .b(r2_r), .y(k1r2),
                                     .clamp(c_k1));
  cam_proj_mul #(.SHIFT(F))  u_m_r6 (.clk(clk), .en(en), .a(r4), .b(r2_d_r[2]), .y(r6),
                                     .clamp(c_r6));
  cam_proj_mul #(.SHIFT(12)) u_m_k2 (.clk(clk), .en(en), .a(k2s), .b(r4), .y(k2r4),
                                     .clamp(c_k2));
  cam_proj_mul #(.SHIFT(12)) u_m_k3 (.clk(clk), .en(en), .a(k3s), .b(r6), .y(k3r6),
                                     .clamp(c_k3));

  assign s_rad1 = sat_add(ONE_NORM, k1r2);
  assign s_rad2 = sat_add(rad1_d_r[2], k2r4);
  assign s_rad3 = sat_add(rad2_d_r[2], k3r6);

  // align intermediate terms with their consumers
  always_ff @(posedge clk) begin
    if (en) begin
      r2_r      <= s_r2.val;
      xx2_r     <= s_xx2.val;
      yy2_r     <= s_yy2.val;
      xy_d_r[0] <= xy;
      for (int k = 1; k < 11; k++) xy_d_r[k] <= xy_d_r[k-1];
      ax_d_r[0] <= s_ax.val;
      ay_d_r[0] <= s_ay.val;
      for (int k = 1; k < 10; k++) begin
        ax_d_r[k] <= ax_d_r[k-1];
        ay_d_r[k] <= ay_d_r[k-1];
      end
      r2_d_r[0]   <= r2_r;
      rad1_d_r[0] <= s_rad1.val;
      rad2_d_r[0] <= s_rad2.val;
      for (int k = 1; k < 3; k++) begin
        r2_d_r[k]   <= r2_d_r[k-1];
        rad1_d_r[k] <= rad1_d_r[k-1];
        rad2_d_r[k] <= rad2_d_r[k-1];
      end
      rad3_r <= s_rad3.val;
    end
  end

  // radial scaling and tangential terms
  cam_proj_mul #(.SHIFT(F))  u_m_xr  (.clk(clk), .en(en), .a(xn_d_r[13]), .b(rad3_r),
                                      .y(xr), .clamp(c_xr));
  cam_proj_mul #(.SHIFT(F))  u_m_yr  (.clk(clk), .en(en), .a(yn_d_r[13]), .b(rad3_r),
                                      .y(yr), .clamp(c_yr));
  cam_proj_mul #(.SHIFT(11)) u_m_xp1 (.clk(clk), .en(en), .a(xy_d_r[10]), .b(p1s),
                                      .y(xp1), .clamp(c_xp1));
  cam_proj_mul #(.SHIFT(12)) u_m_xp2 (.clk(clk), .en(en), .a(ax_d_r[9]), .b(p2s),
                                      .y(xp2), .clamp(c_xp2));
  cam_proj_mul #(.SHIFT(12)) u_m_yp1 (.clk(clk), .en(en), .a(ay_d_r[9]), .b(p1s),
                                      .y(yp1), .clamp(c_yp1));
  cam_proj_mul #(.SHIFT(11)) u_m_yp2 (.clk(clk), .en(en), .a(xy_d_r[10]), .b(p2s),
                                      .y(yp2), .clamp(c_yp2));

  assign s_xa = sat_add(xr, xp1);
  assign s_xd = sat_add(s_xa.val, xp2);
  assign s_ya = sat_add(yr, yp1);
  assign s_yd = sat_add(s_ya.val, yp2);

  always_ff @(posedge clk) begin
    if (en) begin
      xd_r <= s_xd.val;
      yd_r <= s_yd.val;
    end
  end

  // collect distortion clamp flags by the stage that raises them
  always_comb begin
    for (int k = 0; k < 18; k++) dnew[k] = 1'b0;
    dnew[3]  = c_xx | c_yy | c_xy | s_r2.ovf | s_xx2.ovf | s_yy2.ovf;
    dnew[4]  = s_ax.ovf | s_ay.ovf;
    dnew[7]  = c_r4 | c_k1 | s_rad1.ovf;
    dnew[10] = c_r6 | c_k2 | s_rad2.ovf;
    dnew[13] = c_k3 | s_rad3.ovf;
    dnew[17] = c_xr | c_yr | c_xp1 | c_xp2 | c_yp1 | c_yp2
             | s_xa.ovf | s_xd.ovf | s_ya.ovf | s_yd.ovf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dfl_r[0] <= dnew[0];
      for (int k = 1; k < 18; k++) dfl_r[k] <= dfl_r[k-1] | dnew[k];
    end
  end

  // --------------------------------------------------- pixel mapping
  assign xs   = dist_en_r ? xd_r : xn_d_r[17];
  assign ys   = dist_en_r ? yd_r : yn_d_r[17];
  assign fl18 = dvf_d_r[17] | (dist_en_r & dfl_r[17]);
  assign fxs  = {48'd0, lens_r[15:0]};
  assign fys  = {48'd0, lens_r[31:16]};
  assign cxs  = {36'd0, lens_r[47:32], 12'd0};
  assign cys  = {36'd0, lens_r[63:48], 12'd0};

  cam_proj_mul #(.SHIFT(F-12)) u_m_u (.clk(clk), .en(en), .a(xs), .b(fxs), .y(mu),
                                      .clamp(c_mu));
  cam_proj_mul #(.SHIFT(F-12)) u_m_v (.clk(clk), .en(en), .a(ys), .b(fys), .y(mv),
                                      .clamp(c_mv));

  assign s_u = sat_add(mu, cxs);
  assign s_v = sat_add(mv, cys);
  assign pu  = clamp32(s_u.val);
  assign pv  = clamp32(s_v.val);

  always_ff @(posedge clk) begin
    if (en) begin
      fl_d_r[0] <= fl18;
      for (int k = 1; k < 3; k++) fl_d_r[k] <= fl_d_r[k-1];
      u_r   <= pu.val;
      v_r   <= pv.val;
      sat_r <= fl_d_r[2] | c_mu | c_mv | s_u.ovf | s_v.ovf | pu.ovf | pv.ovf;
    end
  end

  // --------------------------------------------------- output register
  assign ld = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld) begin
      out_valid_r <= vld_r[LAST];
    end
  end

  // zero the payload of rejected items
  always_ff @(posedge clk) begin
    if (ld) begin
      out_projected_r <= !rej_d_r[REJ_LEN-1];
      out_pixel_u_r   <= rej_d_r[REJ_LEN-1] ? '0 : u_r;
      out_pixel_v_r   <= rej_d_r[REJ_LEN-1] ? '0 : v_r;
      out_saturated_r <= !rej_d_r[REJ_LEN-1] && sat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_u   = out_pixel_u_r;
  assign out_pixel_v   = out_pixel_v_r;
  assign out_projected = out_projected_r;
  assign out_saturated = out_saturated_r;

  // --------------------------------------------------- assertions
  `CPP_ASSERT(a_rej_zero, (out_valid_r && !out_projected_r) |-> (out_pixel_u_r == '0 && out_pixel_v_r == '0 && !out_saturated_r), "rejected item carries a payload")
  `CPP_ASSERT(a_block_in, (vld_r[LAST] && out_valid_r && !out_ready) |-> !in_ready, "item taken while pipeline is blocked")
  `CPP_ASSERT_NEXT(a_enter, (in_valid && in_ready), vld_r[0], "accepted item lost at entry")
  `CPP_ASSERT_NEXT(a_drain, (out_valid_r && out_ready && !vld_r[LAST]), !out_valid_r, "result repeated after it was taken")

endmodule

`default_nettype wire
